// File: rtl/core/csev_pkg.sv
package csev_pkg;

    // widths shared by the datapath
    localparam int MAX_TERMS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int ACC_W         = 40;
    localparam int T_FRAC        = 30;
    localparam int CNT_CFG_W     = 5;
    localparam int CFG_IDX_W     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_COUNT   = 2'd2;

    // reset values of the interval, -1.0 and +1.0 in Q16.16
    localparam logic signed [DATA_W-1:0] LOW_RST  = -32'sd65536;
    localparam logic signed [DATA_W-1:0] HIGH_RST = 32'sd65536;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DEGEN = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_COEF0,
        ST_OUT
    } state_t;

    // phase control for the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_lo;
        logic mul_hi;
        logic last;
    } mac_ctrl_t;

    // result of the query mapping unit
    typedef struct packed {
        logic                     done;
        logic                     sat;
        logic signed [DATA_W-1:0] t;
    } map_res_t;

endpackage

// File: rtl/core/csev_map.sv
module csev_map (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [csev_pkg::DATA_W-1:0]  query_point,
    input  logic signed [csev_pkg::DATA_W-1:0]  interval_low,
    input  logic signed [csev_pkg::DATA_W-1:0]  interval_high,
    output csev_pkg::map_res_t                  res
);

    localparam int NUM_W = csev_pkg::DATA_W + 3;
    localparam int DEN_W = csev_pkg::DATA_W + 2;
    localparam int AN_W  = csev_pkg::DATA_W + 2;
    localparam int AD_W  = csev_pkg::DATA_W + 1;
    localparam int Q_W   = csev_pkg::DATA_W;
    localparam int DVD_W = AN_W + csev_pkg::T_FRAC;
    localparam int CNT_W = $clog2(Q_W);
    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic [AN_W-1:0]         an;
    logic [AD_W-1:0]         ad;
    logic                    over;
    logic [DVD_W-1:0]        dividend;

    logic [AD_W-1:0]  ad_reg,   ad_next;
    logic [AD_W-1:0]  rem_reg,  rem_next;
    logic [Q_W-1:0]   shq_reg,  shq_next;
    logic             neg_reg,  neg_next;
    logic             over_reg, over_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [AD_W:0]    trial;
    logic             ge;
    logic [Q_W-1:0]   q;

    // map operands: 2x - low - high over high - low
    always_comb
    begin
        num      = (NUM_W'(query_point) <<< 1) - NUM_W'(interval_low) - NUM_W'(interval_high);
        den      = DEN_W'(interval_high) - DEN_W'(interval_low);
        an       = num[NUM_W-1] ? AN_W'(-num) : AN_W'(num);
        ad       = den[DEN_W-1] ? AD_W'(-den) : AD_W'(den);
        over     = an >= {ad, 1'b0};
        dividend = {an, {csev_pkg::T_FRAC{1'b0}}} + DVD_W'(ad[AD_W-1:1]);
    end

    // one restoring division step
    always_comb
    begin
        trial = {rem_reg, shq_reg[Q_W-1]};
        ge    = trial >= {1'b0, ad_reg};
    end

    always_comb
    begin
        ad_next   = ad_reg;
        rem_next  = rem_reg;
        shq_next  = shq_reg;
        neg_next  = neg_reg;
        over_next = over_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            ad_next   = ad;
            rem_next  = AD_W'(dividend[DVD_W-1:Q_W]);
            shq_next  = dividend[Q_W-1:0];
            neg_next  = num[NUM_W-1] ^ den[DEN_W-1];
            over_next = over;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? AD_W'(trial - {1'b0, ad_reg}) : trial[AD_W-1:0];
            shq_next = {shq_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and partial quotient
    always_ff @(posedge clk)
    begin
        ad_reg   <= ad_next;
        rem_reg  <= rem_next;
        shq_reg  <= shq_next;
        neg_reg  <= neg_next;
        over_reg <= over_next;
    end

    // sign and saturation of the quotient into Q2.30
    always_comb
    begin
        q        = shq_reg;
        res.done = done_reg;
        res.sat  = 1'b0;
        if (over_reg)
        begin
            res.sat = 1'b1;
            res.t   = neg_reg ? $signed(Q_MIN) : $signed(Q_MAX);
        end
        else if (neg_reg)
        begin
            res.t = (q > Q_MIN) ? $signed(Q_MIN) : $signed(Q_W'(~q + 1'b1));
        end
        else if (q > Q_MAX)
        begin
            res.sat = 1'b1;
            res.t   = $signed(Q_MAX);
        end
        else
        begin
            res.t = $signed(q);
        end
    end

endmodule

// File: rtl/core/csev_mac.sv
module csev_mac (
    input  logic                                clk,
    input  csev_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [csev_pkg::DATA_W-1:0]  t,
    input  logic signed [csev_pkg::ACC_W-1:0]   b1,
    input  logic signed [csev_pkg::ACC_W-1:0]   b2,
    input  logic signed [csev_pkg::DATA_W-1:0]  coeff,
    output logic signed [csev_pkg::ACC_W-1:0]   b0,
    output logic                                sat
);

    localparam int DW    = csev_pkg::DATA_W;
    localparam int AW    = csev_pkg::ACC_W;
    localparam int HI_W  = AW - DW;
    localparam int P_W   = 2 * DW;
    localparam int PH_W  = DW + HI_W;
    localparam int MAG_W = AW + 4;
    localparam int SUM_W = AW + 6;
    localparam logic signed [SUM_W-1:0] ACC_HI = (SUM_W'(1) << (AW - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] RES_HI = (SUM_W'(1) << (DW - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] RES_LO = -RES_HI - SUM_W'(1);

    logic [DW-1:0]   mt;
    logic [AW-1:0]   mb;
    logic [DW-1:0]   mul_b;
    logic [P_W-1:0]  prod;

    logic [P_W-1:0]  plo_reg;
    logic [PH_W-1:0] phi_reg;
    logic            neg_reg;

    logic [MAG_W-1:0]        mag;
    logic signed [SUM_W-1:0] mext;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lim_hi;
    logic signed [SUM_W-1:0] lim_lo;
    logic signed [SUM_W-1:0] clamped;

    // magnitudes and the shared 32x32 multiplier
    always_comb
    begin
        mt    = t[DW-1] ? (~$unsigned(t) + 1'b1) : $unsigned(t);
        mb    = b1[AW-1] ? (~$unsigned(b1) + 1'b1) : $unsigned(b1);
        mul_b = ctrl.mul_hi ? DW'(mb[AW-1:DW]) : mb[DW-1:0];
        prod  = P_W'(mt) * P_W'(mul_b);
    end

    // partial products
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_lo)
        begin
            plo_reg <= prod;
            neg_reg <= t[DW-1] ^ b1[AW-1];
        end
        if (ctrl.mul_hi)
        begin
            phi_reg <= prod[PH_W-1:0];
        end
    end

    // rounded product, recurrence sum and clamp
    always_comb
    begin
        if (ctrl.last)
        begin
            mag = MAG_W'(plo_reg >> csev_pkg::T_FRAC)
                + MAG_W'(plo_reg[csev_pkg::T_FRAC-1])
                + (MAG_W'(phi_reg) << (DW - csev_pkg::T_FRAC));
            lim_hi = RES_HI;
            lim_lo = RES_LO;
        end
        else
        begin
            mag = MAG_W'(plo_reg >> (csev_pkg::T_FRAC - 1))
                + MAG_W'(plo_reg[csev_pkg::T_FRAC-2])
                + (MAG_W'(phi_reg) << (DW - csev_pkg::T_FRAC + 1));
            lim_hi = ACC_HI;
            lim_lo = ACC_LO;
        end
        mext = $signed(SUM_W'(mag));
        sum  = (neg_reg ? -mext : mext) - SUM_W'(b2) + SUM_W'(coeff);
        sat  = 1'b0;
        if (sum > lim_hi)
        begin
            clamped = lim_hi;
            sat     = 1'b1;
        end
        else if (sum < lim_lo)
        begin
            clamped = lim_lo;
            sat     = 1'b1;
        end
        else
        begin
            clamped = sum;
        end
        b0 = AW'(clamped);
    end

endmodule

// File: rtl/core/chebyshev_series_evaluator.sv
// channel  direction  handshake             word
// in       input      in_valid / in_ready   operation, coeff_index, coeff_value, query_point
// out      output     out_valid / out_ready approx_value, status
// cfg      input      cfg_we                cfg_index, cfg_data
//
// a load word writes its table slot while the sequencer stays idle; an evaluate word with no
// coefficient or a degenerate interval goes straight to ST_OUT, one with one coefficient via ST_COEF0;
// otherwise a bit-serial divider maps the query (ST_MAP), then each recurrence step uses the
// shared 32x32 multiplier twice and accumulates once
// rst_n clears control, sets the interval to [-1.0, 1.0] and the count to 0;
// the coefficient table is not cleared
// a finished result waits in the output register; a second result waits in the last state
module chebyshev_series_evaluator #(
    parameter int MAX_TERMS = csev_pkg::MAX_TERMS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   operation,
    input  logic [3:0]                             coeff_index,
    input  logic signed [csev_pkg::DATA_W-1:0]     coeff_value,
    input  logic signed [csev_pkg::DATA_W-1:0]     query_point,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [csev_pkg::DATA_W-1:0]     approx_value,
    output logic [1:0]                             status,
    input  logic                                   cfg_we,
    input  logic [csev_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [csev_pkg::DATA_W-1:0]            cfg_data
);

    localparam int DW    = csev_pkg::DATA_W;
    localparam int AW    = csev_pkg::ACC_W;
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    csev_pkg::state_t state_reg, state_next;

    logic signed [DW-1:0]            low_reg,   low_next;
    logic signed [DW-1:0]            high_reg,  high_next;
    logic [csev_pkg::CNT_CFG_W-1:0]  count_reg, count_next;

    logic signed [DW-1:0] coef_mem [MAX_TERMS];
    logic signed [DW-1:0] coef_rd_reg;

    logic [IDX_W-1:0]     k_reg,   k_next;
    logic signed [DW-1:0] t_reg,   t_next;
    logic signed [AW-1:0] b1_reg,  b1_next;
    logic signed [AW-1:0] b2_reg,  b2_next;
    logic                 sat_reg, sat_next;
    logic signed [DW-1:0] res_reg, res_next;
    logic [1:0]           rst_reg, rst_next;

    logic                 out_valid_reg,    out_valid_next;
    logic signed [DW-1:0] approx_value_reg, approx_value_next;
    logic [1:0]           status_reg,       status_next;

    logic                 in_accept;
    logic                 is_eval;
    logic                 load_we;
    logic [CNT_W-1:0]     cnt_eff;
    logic                 map_start;
    logic                 out_load;
    csev_pkg::mac_ctrl_t  mac_ctrl;
    csev_pkg::map_res_t   map_res;
    logic signed [AW-1:0] mac_b0;
    logic                 mac_sat;

    assign in_accept = in_valid && in_ready;
    assign is_eval   = operation == csev_pkg::OP_EVAL;
    assign load_we   = in_accept && (operation == csev_pkg::OP_LOAD)
                       && (32'(coeff_index) < 32'(MAX_TERMS));
    assign cnt_eff   = (32'(count_reg) > 32'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(count_reg);

    // configuration registers
    always_comb
    begin
        low_next   = low_reg;
        high_next  = high_reg;
        count_next = count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                csev_pkg::REG_INTERVAL_LOW:  low_next   = $signed(cfg_data);
                csev_pkg::REG_INTERVAL_HIGH: high_next  = $signed(cfg_data);
                csev_pkg::REG_COEFF_COUNT:   count_next = cfg_data[csev_pkg::CNT_CFG_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= csev_pkg::LOW_RST;
            high_reg  <= csev_pkg::HIGH_RST;
            count_reg <= '0;
        end
        else
        begin
            low_reg   <= low_next;
            high_reg  <= high_next;
            count_reg <= count_next;
        end
    end

    // coefficient table, read data always follows the slot index
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            coef_mem[IDX_W'(coeff_index)] <= coeff_value;
        end
        coef_rd_reg <= coef_mem[k_next];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csev_pkg::ST_IDLE:
            begin
                if (in_accept && is_eval)
                begin
                    if (cnt_eff == '0)
                        state_next = csev_pkg::ST_OUT;
                    else if (cnt_eff == CNT_W'(1))
                        state_next = csev_pkg::ST_COEF0;
                    else if (low_reg == high_reg)
                        state_next = csev_pkg::ST_OUT;
                    else
                        state_next = csev_pkg::ST_MAP;
                end
            end
            csev_pkg::ST_MAP:
            begin
                if (map_res.done)
                    state_next = csev_pkg::ST_MUL_LO;
            end
            csev_pkg::ST_MUL_LO: state_next = csev_pkg::ST_MUL_HI;
            csev_pkg::ST_MUL_HI: state_next = csev_pkg::ST_ACC;
            csev_pkg::ST_ACC:
            begin
                state_next = (k_reg == '0) ? csev_pkg::ST_OUT : csev_pkg::ST_MUL_LO;
            end
            csev_pkg::ST_COEF0: state_next = csev_pkg::ST_OUT;
            csev_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = csev_pkg::ST_IDLE;
            end
            default: state_next = csev_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready        = 1'b0;
        map_start       = 1'b0;
        out_load        = 1'b0;
        mac_ctrl.mul_lo = 1'b0;
        mac_ctrl.mul_hi = 1'b0;
        mac_ctrl.last   = k_reg == '0;
        unique case (state_reg)
            csev_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                map_start = in_valid && is_eval && (cnt_eff > CNT_W'(1))
                            && (low_reg != high_reg);
            end
            csev_pkg::ST_MUL_LO: mac_ctrl.mul_lo = 1'b1;
            csev_pkg::ST_MUL_HI: mac_ctrl.mul_hi = 1'b1;
            csev_pkg::ST_OUT:    out_load = !out_valid_reg || out_ready;
            default:             ;
        endcase
    end

    // recurrence registers
    always_comb
    begin
        k_next   = k_reg;
        t_next   = t_reg;
        b1_next  = b1_reg;
        b2_next  = b2_reg;
        sat_next = sat_reg;
        res_next = res_reg;
        rst_next = rst_reg;
        unique case (state_reg)
            csev_pkg::ST_IDLE:
            begin
                res_next = '0;
                rst_next = csev_pkg::STAT_OK;
                if (in_accept && is_eval)
                begin
                    k_next = (cnt_eff > CNT_W'(1)) ? IDX_W'(cnt_eff - 1'b1) : '0;
                    if (cnt_eff > CNT_W'(1) && low_reg == high_reg)
                        rst_next = csev_pkg::STAT_DEGEN;
                end
            end
            csev_pkg::ST_MAP:
            begin
                if (map_res.done)
                begin
                    t_next   = map_res.t;
                    sat_next = map_res.sat;
                    b1_next  = AW'(coef_rd_reg);
                    b2_next  = '0;
                    k_next   = k_reg - 1'b1;
                end
            end
            csev_pkg::ST_ACC:
            begin
                if (k_reg == '0)
                begin
                    res_next = mac_b0[DW-1:0];
                    rst_next = (sat_reg || mac_sat) ? csev_pkg::STAT_SAT : csev_pkg::STAT_OK;
                end
                else
                begin
                    b2_next  = b1_reg;
                    b1_next  = mac_b0;
                    sat_next = sat_reg || mac_sat;
                    k_next   = k_reg - 1'b1;
                end
            end
            csev_pkg::ST_COEF0:
            begin
                res_next = coef_rd_reg;
                rst_next = csev_pkg::STAT_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        t_reg   <= t_next;
        b1_reg  <= b1_next;
        b2_reg  <= b2_next;
        sat_reg <= sat_next;
        res_reg <= res_next;
        rst_reg <= rst_next;
    end

    // output register
    always_comb
    begin
        out_valid_next    = out_ready ? 1'b0 : out_valid_reg;
        approx_value_next = approx_value_reg;
        status_next       = status_reg;
        if (out_load)
        begin
            out_valid_next    = 1'b1;
            approx_value_next = res_reg;
            status_next       = rst_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csev_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        approx_value_reg <= approx_value_next;
        status_reg       <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign approx_value = approx_value_reg;
    assign status       = status_reg;

    // query mapping divider
    csev_map u_map (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (map_start),
        .query_point   (query_point),
        .interval_low  (low_reg),
        .interval_high (high_reg),
        .res           (map_res)
    );

    // shared multiply-accumulate unit
    csev_mac u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .t     (t_reg),
        .b1    (b1_reg),
        .b2    (b2_reg),
        .coeff (coef_rd_reg),
        .b0    (mac_b0),
        .sat   (mac_sat)
    );

`ifndef SYNTHESIS
    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == csev_pkg::ST_OUT))
        else $error("output word raised outside the output state");

    a_map_done_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        map_res.done |-> state_reg == csev_pkg::ST_MAP)
        else $error("divider finished while the sequencer was not waiting");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == csev_pkg::STAT_DEGEN) |-> approx_value_reg == '0)
        else $error("degenerate interval with nonzero value");

    a_step_down: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csev_pkg::ST_ACC && k_reg != '0)
        |=> (state_reg == csev_pkg::ST_MUL_LO && k_reg == $past(k_reg) - 1'b1))
        else $error("recurrence index did not step down");
`endif

endmodule
